### sv/keyword_substitution_cipher_top_defines.svh
// Assertion helpers used by the cipher controller.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ksc: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ksc: assertion failed");

`endif

### sv/ksc_pkg.sv
`default_nettype none

package ksc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = $clog2(LETTERS);

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        MODE_KEY    = 2'd0,
        MODE_FINISH = 2'd1,
        MODE_ENC    = 2'd2,
        MODE_DEC    = 2'd3
    } mode_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_key;    // absorb a keyword byte
        logic start_fill;  // arm the unused-letter walk
        logic fill_step;   // one letter of the walk
        logic take_data;   // look up a data byte
        logic dec;         // lookup uses the inverse table
        logic load_out;    // move the lookup stage into the output register
    } ksc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic key_finished;
        logic fill_last;
    } ksc_status_t;

endpackage

`default_nettype wire

### sv/ksc_ctrl.sv
`default_nettype none

`include "keyword_substitution_cipher_top_defines.svh"

module ksc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire ksc_pkg::mode_t      mode,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire ksc_pkg::ksc_status_t status,
    output ksc_pkg::ksc_cmd_t        cmd
);
    import ksc_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_FILL = 2'b10
    } ctrl_state_t;

    ctrl_state_t st_reg, st_next;
    logic        p1_valid_reg, p1_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        p1_move;
    logic        is_data;

    // Decode the request kind
    always_comb begin
        unique case (mode) inside
            MODE_ENC, MODE_DEC: is_data = 1'b1;
            default:            is_data = 1'b0;
        endcase
    end

    // Advance the lookup stage when the output register frees up
    assign p1_move  = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = (st_reg == ST_RUN) && (!p1_valid_reg || p1_move);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Issue commands
    always_comb begin
        cmd            = '0;
        cmd.take_key   = accept && (mode == MODE_KEY);
        cmd.start_fill = accept && (mode == MODE_FINISH) && !status.key_finished;
        cmd.take_data  = accept && is_data;
        cmd.dec        = (mode == MODE_DEC);
        cmd.fill_step  = (st_reg == ST_FILL);
        cmd.load_out   = p1_move;
    end

    // Sequence the key build
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_RUN: begin
                if (cmd.start_fill) begin
                    st_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (status.fill_last) begin
                    st_next = ST_RUN;
                end
            end
            default: st_next = ST_RUN;
        endcase
    end

    // Track occupancy of the lookup stage and the output register
    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (cmd.take_data) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (p1_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_RUN;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `KSC_ASSERT_NOW(a_no_accept_in_fill, aclk, aresetn, st_reg == ST_FILL, !s_tready)
    `KSC_ASSERT_NEXT(a_fill_holds, aclk, aresetn,
        (st_reg == ST_FILL) && !status.fill_last, st_reg == ST_FILL)
    `KSC_ASSERT_NEXT(a_finish_enters_fill, aclk, aresetn, cmd.start_fill, st_reg == ST_FILL)
    `KSC_ASSERT_NEXT(a_fill_sets_finished, aclk, aresetn,
        (st_reg == ST_FILL) && status.fill_last, status.key_finished)

endmodule

`default_nettype wire

### sv/ksc_datapath.sv
`default_nettype none

module ksc_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [7:0]          data_byte,
    input  wire ksc_pkg::ksc_cmd_t   cmd,
    output ksc_pkg::ksc_status_t     status,
    output logic [7:0]               out_byte,
    output logic                     key_ready
);
    import ksc_pkg::*;

    // Cipher alphabet: forward maps plain to cipher, inverse the reverse
    logic [IDX_W-1:0] fwd_mem [LETTERS];
    logic [IDX_W-1:0] inv_mem [LETTERS];

    logic [LETTERS-1:0] mask_reg;
    logic [IDX_W-1:0]   len_reg;
    logic               finished_reg;
    logic [IDX_W-1:0]   fill_cnt_reg;

    // Lookup stage
    logic [IDX_W-1:0] fwd_rd_reg;
    logic [IDX_W-1:0] inv_rd_reg;
    logic             p1_dec_reg;
    logic             p1_upper_reg;
    logic             p1_letter_reg;
    logic             p1_ready_reg;
    logic [7:0]       p1_byte_reg;

    // Output register
    logic [7:0] out_byte_reg;
    logic       out_ready_reg;

    logic               is_upper, is_lower, is_letter;
    logic [7:0]         base, diff;
    logic [IDX_W-1:0]   idx;
    logic [LETTERS-1:0] mask_base;
    logic [IDX_W-1:0]   len_base;
    logic               key_new;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_pos, wr_letter;
    logic [IDX_W-1:0]   p1_map;
    logic [7:0]         p1_base;

    // Classify the incoming byte
    assign is_upper  = (data_byte >= ASCII_UPPER_A) && (data_byte <= ASCII_UPPER_Z);
    assign is_lower  = (data_byte >= ASCII_LOWER_A) && (data_byte <= ASCII_LOWER_Z);
    assign is_letter = is_upper || is_lower;
    assign base      = is_upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    assign diff      = data_byte - base;
    assign idx       = is_letter ? diff[IDX_W-1:0] : '0;

    // A key byte after a finished key starts over
    assign mask_base = finished_reg ? '0 : mask_reg;
    assign len_base  = finished_reg ? '0 : len_reg;
    assign key_new   = is_letter && !mask_base[idx];

    // Share one write port between key entry and the fill walk
    always_comb begin
        wr_en     = 1'b0;
        wr_pos    = len_reg;
        wr_letter = fill_cnt_reg;
        if (cmd.take_key) begin
            wr_en     = key_new;
            wr_pos    = len_base;
            wr_letter = idx;
        end else if (cmd.fill_step) begin
            wr_en = !mask_reg[fill_cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_mem[wr_pos]    <= wr_letter;
            inv_mem[wr_letter] <= wr_pos;
        end
    end

    // Key state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            len_reg      <= '0;
            finished_reg <= 1'b0;
            fill_cnt_reg <= '0;
        end else begin
            if (cmd.take_key) begin
                mask_reg     <= mask_base
                                | ({{(LETTERS-1){1'b0}}, key_new} << idx);
                len_reg      <= key_new ? len_base + 1'b1 : len_base;
                finished_reg <= 1'b0;
            end
            if (cmd.start_fill) begin
                fill_cnt_reg <= IDX_W'(LETTERS - 1);
            end
            if (cmd.fill_step) begin
                if (wr_en) begin
                    len_reg <= len_reg + 1'b1;
                end
                fill_cnt_reg <= fill_cnt_reg - 1'b1;
                if (status.fill_last) begin
                    finished_reg <= 1'b1;
                end
            end
        end
    end

    assign status.key_finished = finished_reg;
    assign status.fill_last    = (fill_cnt_reg == '0);

    // Read both tables for a data byte
    always_ff @(posedge aclk) begin
        if (cmd.take_data) begin
            fwd_rd_reg    <= fwd_mem[idx];
            inv_rd_reg    <= inv_mem[idx];
            p1_dec_reg    <= cmd.dec;
            p1_upper_reg  <= is_upper;
            p1_letter_reg <= is_letter;
            p1_ready_reg  <= finished_reg;
            p1_byte_reg   <= data_byte;
        end
    end

    // Rebuild the letter in its original case
    assign p1_map  = p1_dec_reg ? inv_rd_reg : fwd_rd_reg;
    assign p1_base = p1_upper_reg ? ASCII_UPPER_A : ASCII_LOWER_A;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_byte_reg  <= (p1_ready_reg && p1_letter_reg)
                             ? p1_base + {{(8-IDX_W){1'b0}}, p1_map}
                             : p1_byte_reg;
            out_ready_reg <= p1_ready_reg;
        end
    end

    assign out_byte  = out_byte_reg;
    assign key_ready = out_ready_reg;

endmodule

`default_nettype wire

### sv/keyword_substitution_cipher_top.sv
// Keyword substitution cipher on a byte stream. Each request carries a kind on
// s_tuser (key byte, finish key, encrypt, decrypt) and a byte on s_tdata. Key
// bytes build the keyword from their ASCII letters, case folded, repeats
// dropped; a key byte after a finished key starts a new keyword. Finish fills
// the alphabet with the unused letters Z down to A. Encrypt and decrypt
// requests return one result each with the letter mapped and its case kept,
// other bytes unchanged; m_tuser is set when a finished key was applied. Key
// and encrypt/decrypt requests are taken one per cycle unless the output
// stalls; a result passes through the lookup stage and the output register,
// and the output register lets the next request in while a result waits. A
// finish that builds a key holds s_tready low while a counter walks the
// alphabet one letter per cycle, writing the single write port of each table.
`default_nettype none

module keyword_substitution_cipher_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_tuser,   // [1:0] mode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [0:0]      m_tuser    // [0] key_ready
);
    import ksc_pkg::*;

    ksc_cmd_t    cmd;
    ksc_status_t status;
    mode_t       mode;
    logic        key_ready;

    assign mode = mode_t'(s_tuser);

    ksc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (mode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ksc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (m_tdata),
        .key_ready (key_ready)
    );

    assign m_tuser = key_ready;

endmodule

`default_nettype wire
